/* hw/rtl/rdc_pkg.sv */
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared constants for the range distinct count unit: default sizes, field
// widths, operation codes and the frequency table epoch width.
// ----------------------------------------------------------------------------
`default_nettype none

package rdc_pkg;

  localparam int ARRAY_DEPTH_DEF = 4096;
  localparam int VALUE_COUNT_DEF = 4096;

  localparam int FIELD_W  = 12;
  localparam int COUNT_W  = 13;
  localparam int S_DATA_W = 4 * FIELD_W;
  localparam int M_DATA_W = 16;

  // Tag width of the frequency entries; a clearing pass runs on every wrap.
  localparam int EPOCH_W = 4;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

`default_nettype wire

/* hw/rtl/range_distinct_count_unit.sv */
// ----------------------------------------------------------------------------
// range_distinct_count_unit
// Distinct values in an inclusive index range, found by sliding a window over
// the element array and keeping a per-value frequency table.
// ----------------------------------------------------------------------------
// A load request writes one value into the element memory and empties the
// window. A query request walks the window ends toward the requested range
// one element at a time (widen low end, widen high end, shrink low end,
// shrink high end); each element moved takes an element read, a frequency
// read and a frequency write-back, in that order. A reversed range answers
// with bad_query set and count zero. Frequency entries carry an epoch tag so
// a load clears the table at once; after reset and on every 2**EPOCH_W-th
// load a clearing pass over all VALUE_COUNT entries runs, during which no
// request is accepted. Results come in arrival order.
`default_nettype none

module range_distinct_count_unit #(
  parameter int ARRAY_DEPTH = rdc_pkg::ARRAY_DEPTH_DEF,
  parameter int VALUE_COUNT = rdc_pkg::VALUE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // position [11:0], value [23:12], query_lo [35:24], query_hi [47:36]
  input  logic [rdc_pkg::S_DATA_W-1:0]  s_tdata,
  // operation
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // distinct_count [12:0], zero [15:13]
  output logic [rdc_pkg::M_DATA_W-1:0]  m_tdata,
  // bad_query
  output logic                          m_tuser
);

  import rdc_pkg::*;

  localparam int AW = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
  localparam int VW = $clog2(VALUE_COUNT);
  localparam int WW = AW + 1;
  localparam int CW = $clog2(ARRAY_DEPTH + 1);
  localparam int FW = EPOCH_W + CW;

  localparam logic [16:0] LAST_POS = 17'(ARRAY_DEPTH - 1);
  localparam logic [16:0] LAST_VAL = 17'(VALUE_COUNT - 1);
  localparam logic [16:0] DEPTH_17 = 17'(ARRAY_DEPTH);
  localparam logic [VW-1:0] LAST_VAL_A = VW'(VALUE_COUNT - 1);
  localparam logic signed [WW-1:0] ONE_W = 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PLAN,
    S_FREQ,
    S_UPD,
    S_DONE
  } state_t;

  state_t                 state;
  logic signed [WW-1:0]   wlo;
  logic signed [WW-1:0]   whi;
  logic signed [WW-1:0]   q_lo;
  logic signed [WW-1:0]   q_hi;
  logic [CW-1:0]          distinct;
  logic [EPOCH_W-1:0]     epoch;
  logic [VW-1:0]          clr_addr;
  logic                   adding;
  logic [VW-1:0]          cur_val;
  logic [COUNT_W-1:0]     res_count;
  logic                   res_bad;

  logic                   s_fire;
  logic [16:0]            pos_ext;
  logic [16:0]            val_ext;
  logic [16:0]            lo_ext;
  logic [16:0]            hi_ext;
  logic [16:0]            val_sat;
  logic [16:0]            lo_sat;
  logic [16:0]            hi_sat;

  logic                   add_lo;
  logic                   add_hi;
  logic                   rem_lo;
  logic                   rem_hi;
  logic signed [WW-1:0]   step_idx;

  logic                   elem_we;
  logic [VW-1:0]          elem_rdata;
  logic                   freq_we;
  logic [VW-1:0]          freq_waddr;
  logic [FW-1:0]          freq_wdata;
  logic [FW-1:0]          freq_rdata;
  logic [CW-1:0]          cnt_eff;
  logic                   upd_we;
  logic [CW-1:0]          cnt_new;

  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;

  assign pos_ext = 17'(s_tdata[FIELD_W-1:0]);
  assign val_ext = 17'(s_tdata[2*FIELD_W-1:FIELD_W]);
  assign lo_ext  = 17'(s_tdata[3*FIELD_W-1:2*FIELD_W]);
  assign hi_ext  = 17'(s_tdata[4*FIELD_W-1:3*FIELD_W]);
  assign val_sat = (val_ext > LAST_VAL) ? LAST_VAL : val_ext;
  assign lo_sat  = (lo_ext > LAST_POS) ? LAST_POS : lo_ext;
  assign hi_sat  = (hi_ext > LAST_POS) ? LAST_POS : hi_ext;

  assign add_lo = (wlo > q_lo);
  assign add_hi = (whi < q_hi);
  assign rem_lo = (wlo < q_lo);
  assign rem_hi = (whi > q_hi);

  always_comb begin
    if (add_lo) begin
      step_idx = wlo - ONE_W;
    end else if (add_hi) begin
      step_idx = whi + ONE_W;
    end else if (rem_lo) begin
      step_idx = wlo;
    end else begin
      step_idx = whi;
    end
  end

  assign elem_we = s_fire && (s_tuser == OP_LOAD) && (pos_ext < DEPTH_17);

  rdc_ram #(
    .WIDTH (VW),
    .DEPTH (ARRAY_DEPTH)
  ) u_elem_ram (
    .clk   (clk),
    .we    (elem_we),
    .waddr (pos_ext[AW-1:0]),
    .wdata (val_sat[VW-1:0]),
    .raddr (step_idx[AW-1:0]),
    .rdata (elem_rdata)
  );

  assign cnt_eff = (freq_rdata[FW-1:CW] == epoch) ? freq_rdata[CW-1:0] : '0;

  always_comb begin
    if (adding) begin
      upd_we  = 1'b1;
      cnt_new = cnt_eff + CW'(1);
    end else begin
      upd_we  = (cnt_eff != '0);
      cnt_new = cnt_eff - CW'(1);
    end
  end

  always_comb begin
    if (state == S_CLEAR) begin
      freq_we    = 1'b1;
      freq_waddr = clr_addr;
      freq_wdata = '0;
    end else begin
      freq_we    = (state == S_UPD) && upd_we;
      freq_waddr = cur_val;
      freq_wdata = {epoch, cnt_new};
    end
  end

  rdc_ram #(
    .WIDTH (FW),
    .DEPTH (VALUE_COUNT)
  ) u_freq_ram (
    .clk   (clk),
    .we    (freq_we),
    .waddr (freq_waddr),
    .wdata (freq_wdata),
    .raddr (elem_rdata),
    .rdata (freq_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      wlo      <= '0;
      whi      <= '1;
      distinct <= '0;
      epoch    <= '0;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + VW'(1);
          if (clr_addr == LAST_VAL_A) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_fire) begin
            if (s_tuser == OP_LOAD) begin
              wlo      <= '0;
              whi      <= '1;
              distinct <= '0;
              epoch    <= epoch + EPOCH_W'(1);
              clr_addr <= '0;
              if (epoch == '1) begin
                state <= S_CLEAR;
              end
            end else if (lo_sat > hi_sat) begin
              res_count <= '0;
              res_bad   <= 1'b1;
              state     <= S_DONE;
            end else begin
              q_lo  <= {1'b0, lo_sat[AW-1:0]};
              q_hi  <= {1'b0, hi_sat[AW-1:0]};
              state <= S_PLAN;
            end
          end
        end
        S_PLAN: begin
          adding <= add_lo || add_hi;
          if (add_lo) begin
            wlo   <= wlo - ONE_W;
            state <= S_FREQ;
          end else if (add_hi) begin
            whi   <= whi + ONE_W;
            state <= S_FREQ;
          end else if (rem_lo) begin
            wlo   <= wlo + ONE_W;
            state <= S_FREQ;
          end else if (rem_hi) begin
            whi   <= whi - ONE_W;
            state <= S_FREQ;
          end else begin
            res_count <= COUNT_W'(distinct);
            res_bad   <= 1'b0;
            state     <= S_DONE;
          end
        end
        S_FREQ: begin
          cur_val <= elem_rdata;
          state   <= S_UPD;
        end
        S_UPD: begin
          if (adding && (cnt_eff == '0)) begin
            distinct <= distinct + CW'(1);
          end else if (!adding && (cnt_eff == CW'(1)) && (distinct != '0)) begin
            distinct <= distinct - CW'(1);
          end
          state <= S_PLAN;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= M_DATA_W'(res_count);
            m_tuser  <= res_bad;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_window_order: assert property (@(posedge clk) disable iff (rst)
    (wlo <= whi) || (wlo == whi + ONE_W))
    else $error("window low end passed high end by more than one");

  a_load_empties: assert property (@(posedge clk) disable iff (rst)
    s_fire && (s_tuser == OP_LOAD) |=> (distinct == '0) && (wlo == '0) && (whi == '1))
    else $error("load did not empty the window");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata == '0))
    else $error("reversed range returned a nonzero count");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_tready && freq_we)
    else $error("request accepted or write missed during clearing pass");
`endif

endmodule

`default_nettype wire

/* hw/rtl/rdc_ram.sv */
// ----------------------------------------------------------------------------
// rdc_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for range_distinct_count_unit. Load requests fill a
// contiguous block of the element array from index zero, plus a few stray
// positions elsewhere. Query requests stay inside that block or are
// reversed ranges. A scoreboard object keeps its own copy of the element
// array, the frequency table and the sliding window. It predicts each query
// answer and compares answers in order. The run covers a directed part, then
// random traffic with sender gaps, receiver stalls and one long receiver
// hold-off.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ELEM_SLOTS  = rdc_pkg::ARRAY_DEPTH_DEF;
  localparam int VALUE_SLOTS = rdc_pkg::VALUE_COUNT_DEF;
  localparam int FW          = rdc_pkg::FIELD_W;

  typedef struct packed {
    logic [rdc_pkg::COUNT_W-1:0] count;
    logic                        bad;
  } answer_t;

  class distinct_window_tracker;
    logic [FW-1:0] elements [ELEM_SLOTS];
    int unsigned   freq [VALUE_SLOTS];
    int            win_lo;
    int            win_hi;
    int unsigned   distinct;
    answer_t       pending[$];
    int            errors;

    function new();
      errors = 0;
      clear_window();
    endfunction

    function void clear_window();
      foreach (freq[i]) freq[i] = 0;
      win_lo = 0;
      win_hi = -1;
      distinct = 0;
    endfunction

    function void add_slot(int idx);
      int v;
      v = elements[idx];
      if (freq[v] == 0) distinct++;
      freq[v]++;
    endfunction

    function void drop_slot(int idx);
      int v;
      v = elements[idx];
      if (freq[v] == 0) return;
      freq[v]--;
      if (freq[v] == 0 && distinct > 0) distinct--;
    endfunction

    function void note_request(logic op, logic [FW-1:0] pos, logic [FW-1:0] val,
                               logic [FW-1:0] lo, logic [FW-1:0] hi);
      answer_t ans;
      int      lo_idx;
      int      hi_idx;
      if (op == rdc_pkg::OP_LOAD) begin
        elements[pos] = val;
        clear_window();
        return;
      end
      lo_idx = lo;
      hi_idx = hi;
      if (lo_idx > hi_idx) begin
        ans.count = '0;
        ans.bad = 1'b1;
      end else begin
        while (win_lo > lo_idx) begin
          win_lo--;
          add_slot(win_lo);
        end
        while (win_hi < hi_idx) begin
          win_hi++;
          add_slot(win_hi);
        end
        while (win_lo < lo_idx) begin
          drop_slot(win_lo);
          win_lo++;
        end
        while (win_hi > hi_idx) begin
          drop_slot(win_hi);
          win_hi--;
        end
        ans.count = distinct[rdc_pkg::COUNT_W-1:0];
        ans.bad = 1'b0;
      end
      pending.push_back(ans);
    endfunction

    function void check_answer(logic [rdc_pkg::M_DATA_W-1:0] data, logic flag);
      answer_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, got data %0h bad_query %0b", $time, data, flag);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (data !== {{(rdc_pkg::M_DATA_W - rdc_pkg::COUNT_W){1'b0}}, want.count}) begin
        $display("%0t: distinct_count expected %0d got data %0h", $time, want.count, data);
        errors++;
      end
      if (flag !== want.bad) begin
        $display("%0t: bad_query expected %0b got %0b", $time, want.bad, flag);
        errors++;
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [rdc_pkg::S_DATA_W-1:0] s_tdata = '0;
  logic                         s_tuser = rdc_pkg::OP_LOAD;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [rdc_pkg::M_DATA_W-1:0] m_tdata;
  logic                         m_tuser;

  distinct_window_tracker tracker = new();

  int send_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_requests = 0;

  bit written [ELEM_SLOTS];
  int loaded_prefix = 0;

  range_distinct_count_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic send_request(input logic op, input logic [FW-1:0] pos,
                              input logic [FW-1:0] val, input logic [FW-1:0] lo,
                              input logic [FW-1:0] hi);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {hi, lo, val, pos};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_request(op, pos, val, lo, hi);
  endtask

  task automatic store_value(input logic [FW-1:0] pos, input logic [FW-1:0] val);
    send_request(rdc_pkg::OP_LOAD, pos, val, FW'($urandom), FW'($urandom));
    written[pos] = 1'b1;
    while (loaded_prefix < ELEM_SLOTS && written[loaded_prefix]) loaded_prefix++;
  endtask

  task automatic ask_range(input logic [FW-1:0] lo, input logic [FW-1:0] hi);
    send_request(rdc_pkg::OP_QUERY, FW'($urandom), FW'($urandom), lo, hi);
  endtask

  initial begin : result_sink
    int stall_left;
    int hold_seen;
    stall_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) tracker.check_answer(m_tdata, m_tuser);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        stall_left = 3000;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  initial begin : stimulus
    int pick;
    int r;
    int a;
    int b;
    logic [FW-1:0] pos;
    logic [FW-1:0] val;
    logic [FW-1:0] lo;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    store_value(12'd0, 12'd0);
    store_value(12'd1, 12'hfff);
    store_value(12'd2, 12'd0);
    store_value(12'd3, 12'hfff);
    store_value(12'd4, 12'h555);
    store_value(12'd5, 12'haaa);
    store_value(12'hfff, 12'hfff);
    store_value(12'haaa, 12'h555);
    ask_range(12'd0, 12'd0);
    ask_range(12'd0, 12'd5);
    ask_range(12'd2, 12'd3);
    ask_range(12'd5, 12'd5);
    ask_range(12'd0, 12'd5);
    ask_range(12'hfff, 12'd0);
    ask_range(12'd3, 12'd2);
    ask_range(12'haaa, 12'h555);
    ask_range(12'd1, 12'd4);
    store_value(12'd2, 12'd7);
    ask_range(12'd0, 12'd5);
    ask_range(12'd3, 12'd3);
    ask_range(12'd0, 12'd4);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          sink_stall_pct <= 0;
          hold_requests <= hold_requests + 1;
        end
        1: begin
          send_idle_pct = 83;
          sink_stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          sink_stall_pct <= 83;
        end
        default: begin
          send_idle_pct = 21;
          sink_stall_pct <= 21;
        end
      endcase
      repeat (200) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          r = $urandom_range(0, 9);
          if (loaded_prefix < 256 && r < 5) pos = FW'(loaded_prefix);
          else if (r < 8) pos = FW'($urandom_range(0, loaded_prefix - 1));
          else pos = FW'($urandom);
          r = $urandom_range(0, 9);
          if (r < 5) val = FW'($urandom_range(0, 7));
          else if (r < 8) val = FW'($urandom);
          else if (r == 8) val = '1;
          else val = '0;
          store_value(pos, val);
        end else if (pick < 23) begin
          lo = FW'($urandom_range(1, ELEM_SLOTS - 1));
          ask_range(lo, FW'($urandom_range(0, lo - 1)));
        end else begin
          a = $urandom_range(0, loaded_prefix - 1);
          if ($urandom_range(0, 9) == 0) b = a;
          else b = $urandom_range(0, loaded_prefix - 1);
          if (a > b) ask_range(FW'(b), FW'(a));
          else ask_range(FW'(a), FW'(b));
        end
      end
    end
    s_tvalid <= 1'b0;

    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #30_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
